@@ sv/rtt_pkg.sv @@
// Shared types, character codes and digit decode for the radix text parser.
`default_nettype none

package rtt_pkg;

    localparam int unsigned ACC_W   = 64;
    localparam int unsigned BITS_W  = 7;
    localparam int unsigned SHIFT_W = 4;

    // configuration register indexes
    localparam logic CFG_RADIX  = 1'b0;
    localparam logic CFG_SIGNED = 1'b1;

    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_F_UP = 8'h46;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_F_LO = 8'h66;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_X_LO = 8'h78;

    localparam logic [BITS_W-1:0] BITS_MAX = BITS_W'(ACC_W);

    // display width codes
    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    // finished string handed from the scanner to the formatter
    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [BITS_W-1:0] bits;
        logic              ovf;
    } t_fin;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
        logic [3:0] nbits;
    } t_digit;

    function automatic t_digit decode_digit(input logic [7:0] c, input logic bin_mode);
        t_digit d;
        d = '{valid: 1'b0, value: 4'd0, nbits: 4'd0};
        if (bin_mode) begin
            if (c == CH_0 || c == CH_1) begin
                d = '{valid: 1'b1, value: {3'b000, c[0]}, nbits: 4'd1};
            end
        end else if (c inside {[CH_0:CH_9]}) begin
            d = '{valid: 1'b1, value: c[3:0], nbits: 4'd4};
        end else if (c inside {[CH_A_UP:CH_F_UP], [CH_A_LO:CH_F_LO]}) begin
            d = '{valid: 1'b1, value: c[3:0] + 4'd9, nbits: 4'd4};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ sv/rtt_if.sv @@
// Request channels: character input and parsed result output.
`default_nettype none

interface rtt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

interface rtt_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] full_value;
    logic [63:0] shown_value;
    logic [6:0]  entered_bits;
    logic [1:0]  width_code;
    logic        too_long;

    modport source (output valid, output full_value, output shown_value,
                    output entered_bits, output width_code, output too_long,
                    input ready);
    modport sink   (input valid, input full_value, input shown_value,
                    input entered_bits, input width_code, input too_long,
                    output ready);
endinterface

`default_nettype wire

@@ sv/rtt_scan.sv @@
// Character scanner: prefix handling, digit shift-in, bit count and the finished-string register.
`default_nettype none

module rtt_scan
    import rtt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_radix,
    rtt_in_if.sink    i_in,
    output logic      o_fin_valid,
    input  wire logic i_fin_ready,
    output t_fin      o_fin
);

    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [BITS_W-1:0] r_bits, n_bits;
    logic [1:0]        r_pos;
    logic              r_lead;
    logic              r_ovf, n_ovf;
    logic              r_fin_valid;
    t_fin              r_fin;

    logic              hex, is_x, lead_set, lead_pend, prefix, zero_pre, tail, take, accept;
    t_digit            dig;
    logic [SHIFT_W-1:0] shamt;
    logic [BITS_W:0]   sum;

    always_comb begin
        hex       = !i_radix;
        is_x      = (i_in.text_char == CH_X_LO) || (i_in.text_char == CH_X_UP);
        lead_set  = (r_pos == 2'd0) && hex && (i_in.text_char == CH_0);
        lead_pend = (r_pos == 2'd1) && r_lead;
        prefix    = lead_pend && hex && is_x;
        zero_pre  = lead_pend && !prefix;
        // a lone held zero at the end of the string counts as one hex digit
        tail      = lead_set && i_in.end_of_text;
        dig       = decode_digit(i_in.text_char, i_radix);
        take      = dig.valid && !lead_set && !prefix;
        shamt     = (zero_pre ? 4'd4 : 4'd0) + (tail ? 4'd4 : 4'd0)
                  + (take ? dig.nbits : 4'd0);
        n_acc     = (r_acc << shamt) | {{(ACC_W-4){1'b0}}, (take ? dig.value : 4'd0)};
        sum       = {1'b0, r_bits} + {{(BITS_W+1-SHIFT_W){1'b0}}, shamt};
        n_bits    = (sum > {1'b0, BITS_MAX}) ? BITS_MAX : sum[BITS_W-1:0];
        n_ovf     = r_ovf || (sum > {1'b0, BITS_MAX});
    end

    assign i_in.ready  = !r_fin_valid || i_fin_ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_bits      <= '0;
            r_pos       <= '0;
            r_lead      <= 1'b0;
            r_ovf       <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            if (accept && i_in.end_of_text) begin
                r_fin       <= '{acc: n_acc, bits: n_bits, ovf: n_ovf};
                r_fin_valid <= 1'b1;
                r_acc       <= '0;
                r_bits      <= '0;
                r_pos       <= '0;
                r_lead      <= 1'b0;
                r_ovf       <= 1'b0;
            end else begin
                if (i_fin_ready) begin
                    r_fin_valid <= 1'b0;
                end
                if (accept) begin
                    r_acc  <= n_acc;
                    r_bits <= n_bits;
                    r_ovf  <= n_ovf;
                    r_lead <= lead_set;
                    if (r_pos != 2'd2) begin
                        r_pos <= r_pos + 2'd1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/rtt_finish.sv @@
// Result formatter: width mask, sign extension, display width and the output register.
`default_nettype none

module rtt_finish
    import rtt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_signed,
    input  wire logic i_fin_valid,
    output logic      o_fin_ready,
    input  wire t_fin i_fin,
    rtt_out_if.source o_out
);

    logic              r_valid;
    logic [ACC_W-1:0]  r_full, r_shown;
    logic [BITS_W-1:0] r_bits;
    logic [1:0]        r_code;
    logic              r_long;

    logic [ACC_W-1:0]  mask, masked, n_full, dmask;
    logic [5:0]        top;
    logic              sext;
    logic [1:0]        n_code;

    always_comb begin
        mask   = i_fin.bits[6] ? '1 : ((64'd1 << i_fin.bits[5:0]) - 64'd1);
        masked = i_fin.acc & mask;
        top    = i_fin.bits[5:0] - 6'd1;
        sext   = i_signed && (i_fin.bits != '0) && !i_fin.bits[6] && i_fin.acc[top];
        n_full = sext ? (masked | ~mask) : masked;
        if (i_fin.bits <= 7'd8) begin
            n_code = WC_8;
        end else if (i_fin.bits <= 7'd16) begin
            n_code = WC_16;
        end else if (i_fin.bits <= 7'd32) begin
            n_code = WC_32;
        end else begin
            n_code = WC_64;
        end
        case (n_code)
            WC_8:    dmask = 64'h0000_0000_0000_00FF;
            WC_16:   dmask = 64'h0000_0000_0000_FFFF;
            WC_32:   dmask = 64'h0000_0000_FFFF_FFFF;
            default: dmask = '1;
        endcase
    end

    assign o_fin_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_fin_valid && o_fin_ready) begin
                r_valid <= 1'b1;
                r_full  <= n_full;
                r_shown <= n_full & dmask;
                r_bits  <= i_fin.bits;
                r_code  <= n_code;
                r_long  <= i_fin.ovf;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.full_value   = r_full;
    assign o_out.shown_value  = r_shown;
    assign o_out.entered_bits = r_bits;
    assign o_out.width_code   = r_code;
    assign o_out.too_long     = r_long;

endmodule

`default_nettype wire

@@ sv/radix_text_to_integer_parser.sv @@
// Radix text parser top level: config registers, scanner and formatter.
// Throughput: one character request per cycle, back to back, while results drain.
// Path: the scanner registers the finished string when its end-of-text character is taken,
//   then the formatter masks and registers the result.
// Reset: synchronous active low; clears string state, pending results and both
//   config registers (hex mode, unsigned view).
`default_nettype none

module radix_text_to_integer_parser
    import rtt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_idx,
    input  wire logic i_cfg_data,
    rtt_in_if.sink    i_in,
    rtt_out_if.source o_out
);

    // config: radix (0 hex, 1 binary) and signed view
    logic r_radix;
    logic r_signed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= 1'b0;
            r_signed <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIX:  r_radix  <= i_cfg_data;
                CFG_SIGNED: r_signed <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // finished string between scanner and formatter
    logic fin_valid;
    logic fin_ready;
    t_fin fin;

    // scanner: strips the 0x prefix, shifts digits in, counts and saturates bits
    rtt_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix     (r_radix),
        .i_in        (i_in),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin       (fin)
    );

    // formatter: masks to entered width, sign-extends, picks display width
    rtt_finish u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_signed    (r_signed),
        .i_fin_valid (fin_valid),
        .o_fin_ready (fin_ready),
        .i_fin       (fin),
        .o_out       (o_out)
    );

    // bit count never exceeds the accumulator width
    a_bits_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.entered_bits <= BITS_MAX))
        else $error("entered_bits above saturation");

    // overflow only with a saturated count
    a_long_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.too_long) |-> (o_out.entered_bits == BITS_MAX))
        else $error("too_long without saturated count");

    // narrow display width keeps the shown value inside one byte
    a_shown_8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.width_code == WC_8)) |->
            ((o_out.entered_bits <= 7'd8) && (o_out.shown_value[63:8] == '0)))
        else $error("byte display width inconsistent");

    // an empty entry yields zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.entered_bits == '0)) |-> (o_out.full_value == '0))
        else $error("empty entry not zero");

endmodule

`default_nettype wire
